// ----- rtl/core/alr_pkg.sv -----
// Shared types, constants and helpers of the antialiased line rasterizer.
package alr_pkg;

	localparam int CW  = 20;	// working coordinate width, 7.8 plus headroom
	localparam int PW  = 12;	// pixel coordinate width
	localparam int DNW = 26;	// divider numerator width
	localparam int DDW = 17;	// divider denominator width
	localparam int DCW = 5;		// divider step counter width
	localparam int GW  = 10;	// gradient width, range -256..256

	localparam logic [1:0] ST_DRAWN  = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_READ   = 2'd2;

	localparam logic signed [CW-1:0] NEG_LIM   = -20'sd255;
	localparam logic signed [CW-1:0] HALF_PIX  = 20'sd128;
	localparam logic [CW-1:0]        SHORT_LEN = 20'd25;
	localparam logic [CW-1:0]        UNIT_LEN  = 20'd256;
	localparam logic [7:0]           FULL_COV  = 8'd255;

	typedef enum logic {
		PX_READ  = 1'b0,
		PX_BLEND = 1'b1
	} px_op_t;

	typedef struct packed {
		logic                 valid;
		px_op_t               op;
		logic signed [PW-1:0] col;
		logic signed [PW-1:0] row;
		logic [7:0]           cov;
		logic [23:0]          color;
		logic [11:0]          idx;
	} px_cmd_t;

	typedef struct packed {
		logic        ready;
		logic        done;
		logic [23:0] rgb;
	} px_rsp_t;

	function automatic logic [7:0] mix8(input logic [7:0] old, input logic [7:0] col,
			input logic [7:0] cov);
		logic [16:0] s;
		s = ({9'd0, old} * {9'd0, cov}) + ({9'd0, col} * {9'd0, FULL_COV - cov});
		return s[15:8];
	endfunction

endpackage

// ----- rtl/core/alr_div.sv -----
// Iterative restoring divider, one quotient bit per cycle, signed result truncated to zero.
module alr_div import alr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [DNW-1:0] num,
	input  logic [DDW-1:0]        den,
	output logic                  done,
	output logic signed [DNW-1:0] quot
);

	logic           busy_q;
	logic [DCW-1:0] cnt_q;
	logic [DDW:0]   rem_q;
	logic [DNW-1:0] q_q;
	logic [DDW-1:0] den_q;
	logic           neg_q;
	logic           done_q;
	logic [DDW:0]   sh;
	logic           ge;

	assign sh = {rem_q[DDW-1:0], q_q[DNW-1]};
	assign ge = sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCW'(DNW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			q_q   <= num[DNW-1] ? DNW'(-num) : DNW'(num);
			den_q <= den;
			neg_q <= num[DNW-1];
		end else if (busy_q) begin
			rem_q <= ge ? sh - {1'b0, den_q} : sh;
			q_q   <= {q_q[DNW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = neg_q ? -$signed(q_q) : $signed(q_q);

endmodule

// ----- rtl/core/alr_fb.sv -----
// Frame store with clear pass and read-modify-write blend unit.
module alr_fb import alr_pkg::*; #(
	parameter int MATRIX_WIDTH  = 64,
	parameter int MATRIX_HEIGHT = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  px_cmd_t cmd,
	output px_rsp_t rsp
);

	localparam int PIX = MATRIX_WIDTH * MATRIX_HEIGHT;
	localparam int AW  = $clog2(PIX);
	localparam logic signed [PW-1:0] WL = PW'(MATRIX_WIDTH);
	localparam logic signed [PW-1:0] HL = PW'(MATRIX_HEIGHT);

	typedef enum logic [3:0] {
		FB_CLR  = 4'b0001,
		FB_IDLE = 4'b0010,
		FB_RD   = 4'b0100,
		FB_MIX  = 4'b1000
	} fb_state_t;

	fb_state_t   state_q;
	logic [23:0] mem [PIX];
	logic [AW-1:0] addr_q, clr_q, waddr;
	logic [23:0] rdat_q, rgb_q, color_q, wdata;
	logic [7:0]  cov_q;
	px_op_t      op_q;
	logic        done_q;
	logic        we;
	logic        on_screen, idx_ok;
	logic [AW-1:0] pix_addr;

	assign on_screen = (cmd.col >= 0) && (cmd.col < WL) && (cmd.row >= 0) && (cmd.row < HL);
	assign idx_ok    = 32'(cmd.idx) < 32'(PIX);
	assign pix_addr  = (cmd.op == PX_READ) ? AW'(cmd.idx)
			: AW'(32'(cmd.row) * MATRIX_WIDTH + 32'(cmd.col));

	assign we    = (state_q == FB_CLR) || (state_q == FB_MIX && op_q == PX_BLEND);
	assign waddr = (state_q == FB_CLR) ? clr_q : addr_q;
	assign wdata = (state_q == FB_CLR) ? 24'd0 : {mix8(rdat_q[23:16], color_q[23:16], cov_q),
			mix8(rdat_q[15:8], color_q[15:8], cov_q), mix8(rdat_q[7:0], color_q[7:0], cov_q)};

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (state_q == FB_RD)
			rdat_q <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FB_CLR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				FB_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(PIX - 1))
						state_q <= FB_IDLE;
				end
				FB_IDLE: begin
					if (cmd.valid) begin
						if ((cmd.op == PX_READ) ? idx_ok : on_screen)
							state_q <= FB_RD;
						else
							done_q <= 1'b1;
					end
				end
				FB_RD: state_q <= FB_MIX;
				FB_MIX: begin
					state_q <= FB_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= FB_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FB_IDLE && cmd.valid) begin
			addr_q  <= pix_addr;
			op_q    <= cmd.op;
			cov_q   <= cmd.cov;
			color_q <= cmd.color;
			rgb_q   <= '0;
		end else if (state_q == FB_MIX && op_q == PX_READ) begin
			rgb_q <= rdat_q;
		end
	end

	assign rsp.ready = state_q != FB_CLR;
	assign rsp.done  = done_q;
	assign rsp.rgb   = rgb_q;

endmodule

// ----- rtl/core/antialiased_line_rasterizer_top.sv -----
// Top level: request sequencer around the divider and the frame store unit.
//
// Input stream s_*: one transaction per request. s_tuser is the request type
// (0 draw line, 1 read pixel); s_tdata carries endpoints, colour and pixel index.
// Output stream m_*: exactly one transaction per request; m_tuser is the status
// (0 drawn, 1 rejected, 2 read data), m_tdata the pixel read (zero for draws).
// One request is worked on at a time; s_tready is low until its result has been
// loaded into the output register. A draw runs its setup, the gradient divider
// when the line is 25 7.8-units or longer, then the two-pixel read-modify-write
// loop of the frame store (one port) for each major-axis column.
// After reset the frame store is cleared one pixel a cycle, all MATRIX_WIDTH *
// MATRIX_HEIGHT pixels (4096 by default), with s_tready low meanwhile.
// A stalled m_tready holds the result; the block finishes the next request and
// then waits for the output register to empty.
module antialiased_line_rasterizer_top import alr_pkg::*; #(
	parameter int MATRIX_WIDTH  = 64,
	parameter int MATRIX_HEIGHT = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,	// x_start, y_start, x_end, y_end, color_red,
					// color_green, color_blue, pixel_index, zero pad
	input  logic         s_tuser,	// req_type
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [23:0]  m_tdata,	// read_red, read_green, read_blue
	output logic [1:0]   m_tuser	// status
);

	localparam logic signed [PW-1:0] WL = PW'(MATRIX_WIDTH);
	localparam logic signed [PW-1:0] HL = PW'(MATRIX_HEIGHT);

	typedef enum logic [15:0] {
		S_IDLE  = 16'h0001,
		S_CHECK = 16'h0002,
		S_RDW   = 16'h0004,
		S_ORDER = 16'h0008,
		S_SETUP = 16'h0010,
		S_DIV   = 16'h0020,
		S_SHORT = 16'h0040,
		S_EPMUL = 16'h0080,
		S_EPADD = 16'h0100,
		S_EPCOV = 16'h0200,
		S_BL0   = 16'h0400,
		S_BL0W  = 16'h0800,
		S_BL1   = 16'h1000,
		S_BL1W  = 16'h2000,
		S_SPAN  = 16'h4000,
		S_DONE  = 16'h8000
	} seq_state_t;

	function automatic logic signed [CW-1:0] half_tz(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] r;
		r = v + $signed({{(CW-1){1'b0}}, v[CW-1]});
		return r >>> 1;
	endfunction

	seq_state_t state_q;
	logic       req_q, steep_q, ep_q, span_q;
	logic signed [CW-1:0] x1_q, y1_q, x2_q, y2_q, ye_q, yf_q;
	logic [CW-1:0]        xd_q;
	logic [23:0]          color_q, rgb_q;
	logic [11:0]          idx_q;
	logic signed [GW-1:0] grad_q;
	logic signed [18:0]   prod_q;
	logic [7:0]           gap_q, cov_q;
	logic signed [PW-1:0] yi_q, ccol_q, c1_q, c2_q;
	logic [1:0]           status_q;
	logic                 m_valid_q;
	logic [1:0]           m_user_q;
	logic [23:0]          m_data_q;

	logic signed [CW-1:0] dx, dy, adx, ady, xs, ys, xsh, xe, dxe, sx, sy, ye_n, gradw, gh;
	logic                 reject;
	logic [15:0]          covm;
	logic                 div_start, div_done;
	logic signed [DNW-1:0] div_quot;
	px_cmd_t              cmd;
	px_rsp_t              rsp;
	logic signed [PW-1:0] minor;

	assign dx  = x2_q - x1_q;
	assign dy  = y2_q - y1_q;
	assign adx = dx[CW-1] ? -dx : dx;
	assign ady = dy[CW-1] ? -dy : dy;
	assign reject = (x1_q < NEG_LIM && x2_q < NEG_LIM) || (y1_q < NEG_LIM && y2_q < NEG_LIM)
			|| ($signed(x1_q[CW-1:8]) >= WL && $signed(x2_q[CW-1:8]) >= WL)
			|| ($signed(y1_q[CW-1:8]) >= HL && $signed(y2_q[CW-1:8]) >= HL);

	assign xs    = ep_q ? x2_q : x1_q;
	assign ys    = ep_q ? y2_q : y1_q;
	assign xsh   = xs + HALF_PIX;
	assign xe    = $signed({xsh[CW-1:8], 8'd0});
	assign dxe   = xe - xs;
	assign sx    = half_tz(x1_q + x2_q);
	assign sy    = half_tz(y1_q + y2_q);
	assign gradw = CW'(grad_q);
	assign gh    = half_tz(gradw);
	assign ye_n  = ys + CW'(prod_q >>> 8);
	assign covm  = ye_q[7:0] * gap_q;

	assign div_start = state_q == S_SETUP && xd_q >= SHORT_LEN;

	alr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (DNW'(DNW'(dy) <<< 8)),
		.den    (xd_q[DDW-1:0]),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign minor     = (state_q == S_BL1) ? yi_q + 1'b1 : yi_q;
	assign cmd.valid = state_q == S_BL0 || state_q == S_BL1 || (state_q == S_CHECK && req_q);
	assign cmd.op    = (state_q == S_CHECK) ? PX_READ : PX_BLEND;
	assign cmd.col   = steep_q ? minor : ccol_q;
	assign cmd.row   = steep_q ? ccol_q : minor;
	assign cmd.cov   = (state_q == S_BL1) ? FULL_COV - cov_q : cov_q;
	assign cmd.color = color_q;
	assign cmd.idx   = idx_q;

	alr_fb #(
		.MATRIX_WIDTH  (MATRIX_WIDTH),
		.MATRIX_HEIGHT (MATRIX_HEIGHT)
	) u_fb (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			if (m_valid_q && m_tready && state_q != S_DONE)
				m_valid_q <= 1'b0;
			case (state_q)
				S_IDLE:  if (s_tvalid && s_tready) state_q <= S_CHECK;
				S_CHECK: begin
					if (req_q)
						state_q <= S_RDW;
					else if (reject)
						state_q <= S_DONE;
					else
						state_q <= S_ORDER;
				end
				S_RDW:   if (rsp.done) state_q <= S_DONE;
				S_ORDER: state_q <= S_SETUP;
				S_SETUP: state_q <= (xd_q < SHORT_LEN) ? S_EPMUL : S_DIV;
				S_DIV:   if (div_done) state_q <= (xd_q < UNIT_LEN) ? S_SHORT : S_EPMUL;
				S_SHORT: state_q <= S_EPMUL;
				S_EPMUL: state_q <= S_EPADD;
				S_EPADD: state_q <= S_EPCOV;
				S_EPCOV: state_q <= S_BL0;
				S_BL0:   state_q <= S_BL0W;
				S_BL0W:  if (rsp.done) state_q <= S_BL1;
				S_BL1:   state_q <= S_BL1W;
				S_BL1W: begin
					if (rsp.done)
						state_q <= (span_q || ep_q) ? S_SPAN : S_EPMUL;
				end
				S_SPAN:  state_q <= (c1_q < c2_q) ? S_BL0 : S_DONE;
				S_DONE: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				req_q   <= s_tuser;
				x1_q    <= CW'($signed(s_tdata[15:0]));
				y1_q    <= CW'($signed(s_tdata[31:16]));
				x2_q    <= CW'($signed(s_tdata[47:32]));
				y2_q    <= CW'($signed(s_tdata[63:48]));
				color_q <= s_tdata[87:64];
				idx_q   <= s_tdata[99:88];
				steep_q <= 1'b0;
				ep_q    <= 1'b0;
				span_q  <= 1'b0;
				rgb_q   <= '0;
			end
			S_CHECK: begin
				status_q <= req_q ? ST_READ : (reject ? ST_REJECT : ST_DRAWN);
				if (adx < ady) begin
					steep_q <= 1'b1;
					x1_q <= y1_q;
					y1_q <= x1_q;
					x2_q <= y2_q;
					y2_q <= x2_q;
				end
			end
			S_RDW: if (rsp.done) rgb_q <= rsp.rgb;
			S_ORDER: begin
				if (x2_q < x1_q) begin
					x1_q <= x2_q;
					x2_q <= x1_q;
					y1_q <= y2_q;
					y2_q <= y1_q;
					xd_q <= x1_q - x2_q;
				end else begin
					xd_q <= x2_q - x1_q;
				end
			end
			S_SETUP: begin
				if (xd_q < SHORT_LEN) begin
					x1_q   <= x1_q - HALF_PIX;
					x2_q   <= x1_q + HALF_PIX;
					grad_q <= '0;
				end
			end
			S_DIV: if (div_done) grad_q <= div_quot[GW-1:0];
			S_SHORT: begin
				x1_q   <= sx - HALF_PIX;
				x2_q   <= sx + HALF_PIX;
				y1_q   <= sy - gh;
				y2_q   <= sy + gh;
				grad_q <= '0;
			end
			S_EPMUL: begin
				prod_q <= grad_q * $signed(dxe[8:0]);
				ccol_q <= $signed(xsh[CW-1:8]);
				gap_q  <= ep_q ? xs[7:0] : FULL_COV - xs[7:0];
			end
			S_EPADD: ye_q <= ye_n;
			S_EPCOV: begin
				cov_q <= covm[15:8];
				yi_q  <= $signed(ye_q[CW-1:8]);
				if (!ep_q) begin
					c1_q <= ccol_q + 1'b1;
					yf_q <= ye_q + gradw;
				end else begin
					c2_q <= ccol_q;
				end
			end
			S_BL1W: begin
				if (rsp.done) begin
					if (span_q) begin
						c1_q <= c1_q + 1'b1;
						yf_q <= yf_q + gradw;
					end else if (!ep_q) begin
						ep_q <= 1'b1;
					end else begin
						span_q <= 1'b1;
					end
				end
			end
			S_SPAN: begin
				ccol_q <= c1_q;
				cov_q  <= yf_q[7:0];
				yi_q   <= $signed(yf_q[CW-1:8]);
			end
			S_DONE: begin
				if (!m_valid_q || m_tready) begin
					m_user_q <= status_q;
					m_data_q <= rgb_q;
				end
			end
			default: ;
		endcase
	end

	assign s_tready = state_q == S_IDLE && rsp.ready;
	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_user_q;
	assign m_tdata  = m_data_q;

endmodule

// ----- rtl/core/alr_chk.sv -----
// Port-level checker for the rasterizer top, bound to every instance.
module alr_chk import alr_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [103:0] s_tdata,
	input logic         s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [23:0]  m_tdata,
	input logic [1:0]   m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tuser) && $stable(m_tdata))
		else $error("output transaction dropped or changed under stall");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= ST_READ)
		else $error("undefined status code");

	a_draw_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_READ |-> m_tdata == 24'd0)
		else $error("draw result carries pixel data");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while previous one in flight");

	a_reset_busy: assert property (@(posedge clk)
		!arst_n |-> !s_tready && !m_tvalid)
		else $error("ports active during reset");

endmodule

bind antialiased_line_rasterizer_top alr_chk u_alr_chk (.*);

// ----- bench/alr_checker.sv -----
`timescale 1ns / 100ps
// Checker for the line rasterizer: predicts frame store contents and checks each result.
module alr_checker import alr_pkg::*; #(
	parameter int MATRIX_WIDTH  = 64,
	parameter int MATRIX_HEIGHT = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [103:0] s_tdata,
	input  logic         s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [23:0]  m_tdata,
	input  logic [1:0]   m_tuser,
	output int           errors,
	output int           pending,
	output int           n_drawn,
	output int           n_rejected,
	output int           n_reads
);

	typedef struct {
		logic [1:0] status;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_result_t;

	logic [23:0]   frame [MATRIX_WIDTH*MATRIX_HEIGHT];
	pixel_result_t awaited[$];

	initial begin
		errors = 0;
		n_drawn = 0;
		n_rejected = 0;
		n_reads = 0;
		foreach (frame[i]) frame[i] = '0;
	end

	assign pending = awaited.size();

	function automatic int fl256(int v);
		return v >>> 8;
	endfunction

	function automatic int mix(int old, int c, int cov);
		return ((old * cov + c * (255 - cov)) >> 8) & 255;
	endfunction

	task automatic blend(int maj, int mnr, bit steep, int cov, logic [23:0] c);
		int col, row, idx;
		logic [23:0] p;
		col = steep ? mnr : maj;
		row = steep ? maj : mnr;
		if (col < 0 || col >= MATRIX_WIDTH || row < 0 || row >= MATRIX_HEIGHT) return;
		idx = row * MATRIX_WIDTH + col;
		p = frame[idx];
		cov = cov & 255;
		frame[idx] = {8'(mix(p[23:16], c[23:16], cov)), 8'(mix(p[15:8], c[15:8], cov)),
			8'(mix(p[7:0], c[7:0], cov))};
	endtask

	task automatic render_line(int x1, int y1, int x2, int y2, logic [23:0] c,
			output logic [1:0] status);
		bit steep;
		int t, xd, grad, xe, ye, yf, c1, c2, yi, gap, cov, xm, ym;
		steep = 0;
		if ((x1 < -255 && x2 < -255) || (y1 < -255 && y2 < -255) ||
				(fl256(x1) >= MATRIX_WIDTH && fl256(x2) >= MATRIX_WIDTH) ||
				(fl256(y1) >= MATRIX_HEIGHT && fl256(y2) >= MATRIX_HEIGHT)) begin
			status = ST_REJECT;
			return;
		end
		status = ST_DRAWN;
		if ((x2 - x1 < 0 ? x1 - x2 : x2 - x1) < (y2 - y1 < 0 ? y1 - y2 : y2 - y1)) begin
			steep = 1;
			t = x1; x1 = y1; y1 = t;
			t = x2; x2 = y2; y2 = t;
		end
		if (x2 < x1) begin
			t = x1; x1 = x2; x2 = t;
			t = y1; y1 = y2; y2 = t;
		end
		xd = x2 - x1;
		if (xd < 25) begin
			x2 = x1 + 128;
			x1 = x1 - 128;
			grad = 0;
		end else begin
			grad = ((y2 - y1) * 256) / xd;
			if (xd < 256) begin
				xm = (x1 + x2) / 2;
				ym = (y1 + y2) / 2;
				x1 = xm - 128;
				x2 = xm + 128;
				y1 = ym - grad / 2;
				y2 = ym + grad / 2;
				grad = 0;
			end
		end
		xe = fl256(x1 + 128) * 256;
		ye = y1 + fl256(grad * (xe - x1));
		gap = 255 - (x1 & 255);
		cov = ((ye & 255) * gap) >> 8;
		c1 = fl256(xe);
		yi = fl256(ye);
		blend(c1, yi, steep, cov, c);
		blend(c1, yi + 1, steep, 255 - cov, c);
		c1++;
		yf = ye + grad;
		xe = fl256(x2 + 128) * 256;
		ye = y2 + fl256(grad * (xe - x2));
		gap = x2 & 255;
		cov = ((ye & 255) * gap) >> 8;
		c2 = fl256(xe);
		yi = fl256(ye);
		blend(c2, yi, steep, cov, c);
		blend(c2, yi + 1, steep, 255 - cov, c);
		while (c1 < c2) begin
			cov = yf & 255;
			yi = fl256(yf);
			blend(c1, yi, steep, cov, c);
			blend(c1, yi + 1, steep, 255 - cov, c);
			yf += grad;
			c1++;
		end
	endtask

	task automatic report(string field, int want, int got);
		$display("%0t: mismatch on %s: expected %0d, got %0d", $time, field, want, got);
		errors++;
	endtask

	always @(posedge clk) begin
		pixel_result_t e;
		logic [23:0] p;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				e = '{ST_READ, 8'd0, 8'd0, 8'd0};
				if (s_tuser) begin
					n_reads++;
					if (s_tdata[99:88] < MATRIX_WIDTH * MATRIX_HEIGHT) begin
						p = frame[s_tdata[99:88]];
						e.red = p[23:16];
						e.green = p[15:8];
						e.blue = p[7:0];
					end
				end else begin
					render_line(int'($signed(s_tdata[15:0])), int'($signed(s_tdata[31:16])),
						int'($signed(s_tdata[47:32])), int'($signed(s_tdata[63:48])),
						{s_tdata[71:64], s_tdata[79:72], s_tdata[87:80]}, e.status);
					if (e.status == ST_DRAWN) n_drawn++;
					else n_rejected++;
				end
				awaited.push_back(e);
			end
			if (m_tvalid && m_tready) begin
				if (awaited.size() == 0) begin
					report("outstanding transactions", 0, 1);
				end else begin
					e = awaited.pop_front();
					if (m_tuser != e.status) report("status", e.status, m_tuser);
					if (m_tdata[7:0] != e.red) report("red", e.red, m_tdata[7:0]);
					if (m_tdata[15:8] != e.green) report("green", e.green, m_tdata[15:8]);
					if (m_tdata[23:16] != e.blue) report("blue", e.blue, m_tdata[23:16]);
				end
			end
		end
	end

endmodule

// ----- bench/antialiased_line_rasterizer_top_test.sv -----
`timescale 1ns / 100ps
// Testbench top for the line rasterizer: stimulus, stall patterns and verdict.
module antialiased_line_rasterizer_top_test;
	import alr_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [23:0]  m_tdata;
	logic [1:0]   m_tuser;
	int           errors, pending, n_drawn, n_rejected, n_reads;
	int           tx_idle_pct, rx_stall_pct;
	logic         rx_hold;

	antialiased_line_rasterizer_top dut (.*);

	alr_checker chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("TEST FAILED");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
		end
	end

	task automatic send(bit rd, int xs, int ys, int xe, int ye, int r, int g, int b, int idx);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= rd;
		s_tdata <= {4'd0, 12'(idx), 8'(b), 8'(g), 8'(r), 16'(ye), 16'(xe), 16'(ys), 16'(xs)};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	function automatic int coord();
		return $urandom_range(70 * 256) - 3 * 256;
	endfunction

	task automatic random_item();
		int xs, ys, xe, ye, k;
		k = $urandom_range(99);
		if (k < 40) begin
			send(1, 0, 0, 0, 0, $urandom_range(255), $urandom_range(255), $urandom_range(255),
				$urandom_range(4095));
			return;
		end
		xs = coord();
		ys = coord();
		if (k < 70) begin
			xe = coord();
			ye = coord();
		end else if (k < 85) begin
			xe = xs + $urandom_range(600) - 300;
			ye = ys + $urandom_range(600) - 300;
		end else if (k < 93) begin
			xs = $signed(16'($urandom));
			ys = $signed(16'($urandom));
			xe = $signed(16'($urandom));
			ye = $signed(16'($urandom));
		end else begin
			xe = ($urandom_range(1)) ? 32767 : -32768;
			ye = $signed(16'($urandom));
		end
		send(0, xs, ys, xe, ye, $urandom_range(255), $urandom_range(255), $urandom_range(255),
			$urandom_range(4095));
	endtask

	initial begin
		int idle_set [4] = '{0, 72, 0, 15};
		int stall_set [4] = '{0, 0, 72, 15};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		rx_hold = 1'b0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed cases
		send(1, 0, 0, 0, 0, 0, 0, 0, 0);
		send(0, 0, 0, 63 * 256, 0, 255, 255, 255, 0);
		send(0, 10 * 256, 0, 12 * 256, 63 * 256, 255, 0, 128, 0);
		send(0, 63 * 256 + 200, 63 * 256, 0, 10, 0, 255, 0, 0);
		send(0, 5 * 256, 5 * 256, 5 * 256 + 10, 5 * 256 + 3, 200, 100, 50, 0);
		send(0, 20 * 256, 30 * 256, 20 * 256 + 100, 30 * 256 + 40, 9, 99, 199, 0);
		send(0, 40 * 256, 40 * 256, 40 * 256 + 30, 40 * 256 - 200, 1, 2, 3, 0);
		send(0, -300, 5 * 256, -1000, 20 * 256, 255, 255, 255, 0);
		send(0, 5 * 256, -256, 20 * 256, -32768, 255, 255, 255, 0);
		send(0, 64 * 256, 5 * 256, 32767, 9 * 256, 255, 255, 255, 0);
		send(0, 5 * 256, 64 * 256, 8 * 256, 32767, 255, 255, 255, 0);
		send(0, -32768, -32768, 32767, 32767, 77, 88, 99, 0);
		send(0, 32767, -32768, -32768, 32767, 255, 0, 255, 0);
		send(0, -255, -255, 63 * 256 + 255, 63 * 256 + 255, 12, 34, 56, 0);
		send(0, -200, 30 * 256, 70 * 256, 31 * 256, 100, 100, 100, 0);
		send(0, 0, 0, 0, 0, 255, 255, 255, 0);
		send(1, 0, 0, 0, 0, 0, 0, 0, 0);
		send(1, 0, 0, 0, 0, 0, 0, 0, 4095);
		send(1, 0, 0, 0, 0, 0, 0, 0, 65);
		send(1, 0, 0, 0, 0, 0, 0, 0, 2080);
		send(1, 0, 0, 0, 0, 0, 0, 0, 2730);
		send(1, 0, 0, 0, 0, 0, 0, 0, 1365);

		for (int ph = 0; ph < 4; ph++) begin
			tx_idle_pct = idle_set[ph];
			rx_stall_pct = stall_set[ph];
			if (ph == 0) begin
				fork
					begin
						rx_hold <= 1'b1;
						repeat (4000) @(posedge clk);
						rx_hold <= 1'b0;
					end
				join_none
			end
			for (int i = 0; i < 482; i++) random_item();
		end
		s_tvalid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("Covered %0d draws, %0d rejected lines and %0d pixel reads",
			n_drawn, n_rejected, n_reads);
		$display("across four sender/receiver idle mixes and one long output hold-off.");
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
